@@ hw/rtl/r2y420_pkg.sv @@
// Shared constants and coefficients for the RGB to YUV 4:2:0 converter.
`timescale 1ns / 1ps

package r2y420_pkg;

  localparam int MAX_WIDTH          = 4096;
  localparam int MAX_HEIGHT         = 4096;
  localparam int COEF_FRACTION_BITS = 16;

  localparam int PIX_W       = 8;
  localparam int SUM_W       = PIX_W + 1;
  localparam int ENTRY_W     = 3 * SUM_W;
  localparam int LINE_DEPTH  = MAX_WIDTH / 2;
  localparam int LINE_ADDR_W = $clog2(LINE_DEPTH);
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);
  localparam int WLIM_W      = COL_W + 1;
  localparam int HLIM_W      = ROW_W + 1;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 13;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = CFG_INDEX_W'(1);

  localparam logic [WLIM_W-1:0] WIDTH_RESET  = WLIM_W'(640);
  localparam logic [HLIM_W-1:0] HEIGHT_RESET = HLIM_W'(480);

  // Q0.F coefficients, truncated
  localparam int     COEF_W = COEF_FRACTION_BITS;
  localparam longint ONE_Q  = longint'(1) << COEF_FRACTION_BITS;
  localparam logic [COEF_W-1:0] COEF_YR = COEF_W'((257 * ONE_Q) / 1000);
  localparam logic [COEF_W-1:0] COEF_YG = COEF_W'((504 * ONE_Q) / 1000);
  localparam logic [COEF_W-1:0] COEF_YB = COEF_W'((98 * ONE_Q) / 1000);
  localparam logic [COEF_W-1:0] COEF_UR = COEF_W'((148 * ONE_Q) / 1000);
  localparam logic [COEF_W-1:0] COEF_UG = COEF_W'((291 * ONE_Q) / 1000);
  localparam logic [COEF_W-1:0] COEF_UV = COEF_W'((439 * ONE_Q) / 1000);
  localparam logic [COEF_W-1:0] COEF_VG = COEF_W'((368 * ONE_Q) / 1000);
  localparam logic [COEF_W-1:0] COEF_VB = COEF_W'((71 * ONE_Q) / 1000);

  // accumulator: three products of COEF_W + PIX_W bits plus offset headroom
  localparam int ACC_W = COEF_FRACTION_BITS + PIX_W + 2;
  localparam logic [ACC_W-1:0] CHROMA_OFFSET = ACC_W'(128 * ONE_Q);
  localparam logic [PIX_W-1:0] LUMA_OFFSET   = PIX_W'(16);

endpackage

@@ hw/rtl/r2y420_if.sv @@
// Stream and configuration interfaces of the RGB to YUV 4:2:0 converter.
`timescale 1ns / 1ps

interface r2y420_pix_if;
  logic                        valid;
  logic                        ready;
  logic [r2y420_pkg::PIX_W-1:0] red;
  logic [r2y420_pkg::PIX_W-1:0] green;
  logic [r2y420_pkg::PIX_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface r2y420_res_if;
  logic                        valid;
  logic                        ready;
  logic [r2y420_pkg::PIX_W-1:0] luma;
  logic                        chroma_valid;
  logic [r2y420_pkg::PIX_W-1:0] chroma_blue;
  logic [r2y420_pkg::PIX_W-1:0] chroma_red;
  logic                        frame_last;

  modport source (output valid, output luma, output chroma_valid, output chroma_blue,
                  output chroma_red, output frame_last, input ready);
  modport sink   (input valid, input luma, input chroma_valid, input chroma_blue,
                  input chroma_red, input frame_last, output ready);
endinterface

interface r2y420_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [r2y420_pkg::CFG_INDEX_W-1:0] index;
  logic [r2y420_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/r2y420_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module r2y420_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wen,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     ren,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/rgb_to_yuv420_converter.sv @@
// Top level: streaming BT.601 studio-range RGB to YUV 4:2:0 converter.
//
// Usage:
//   pixels  - RGB requests in raster order, one 8-bit red/green/blue triple each.
//   results - one request per pixel: luma always; chroma_valid with chroma_blue
//             and chroma_red on the bottom-right pixel of each 2x2 block (chroma
//             fields read zero otherwise); frame_last on the frame's last pixel.
//   cfg     - register writes: index 0 frame width, index 1 frame height. Sizes
//             are forced even and clamped to 2..4096. Always ready. Write only
//             while no pixel is in flight.
// A result is registered in stage 1, then in the result register, after its pixel
// is accepted; throughput is one pixel per cycle while results is not stalled, set
// by the two register stages (input/average stage, then constant multiply stage)
// and the single line-store RAM of pair sums.
// The line store is read on the even pixel of a pair and used on the odd one.
// Reset clears counters and pipeline valids, sets 640x480, and needs no RAM
// clearing. When results stalls, the stage-1 register still takes one more
// pixel; pixels.ready drops only when both stages are full.
`timescale 1ns / 1ps

module rgb_to_yuv420_converter (
  input logic              clk,
  input logic              rst,
  r2y420_pix_if.sink       pixels,
  r2y420_res_if.source     results,
  r2y420_cfg_if.sink       cfg
);

  typedef struct packed {
    logic [r2y420_pkg::PIX_W-1:0] red;
    logic [r2y420_pkg::PIX_W-1:0] green;
    logic [r2y420_pkg::PIX_W-1:0] blue;
    logic [r2y420_pkg::PIX_W-1:0] avg_red;
    logic [r2y420_pkg::PIX_W-1:0] avg_green;
    logic [r2y420_pkg::PIX_W-1:0] avg_blue;
    logic                         chroma_valid;
    logic                         frame_last;
  } stage_t;

  localparam int PW = r2y420_pkg::PIX_W;
  localparam int SW = r2y420_pkg::SUM_W;
  localparam int F  = r2y420_pkg::COEF_FRACTION_BITS;
  localparam int AW = r2y420_pkg::ACC_W;

  // configuration
  logic [r2y420_pkg::WLIM_W-1:0] width_lim;
  logic [r2y420_pkg::HLIM_W-1:0] height_lim;
  int                            cfg_even;
  int                            width_clamped;
  int                            height_clamped;

  always_comb begin
    cfg_even = int'({cfg.data[r2y420_pkg::CFG_DATA_W-1:1], 1'b0});
    width_clamped = cfg_even;
    if (cfg_even < 2) begin
      width_clamped = 2;
    end else if (cfg_even > r2y420_pkg::MAX_WIDTH) begin
      width_clamped = r2y420_pkg::MAX_WIDTH;
    end
    height_clamped = cfg_even;
    if (cfg_even < 2) begin
      height_clamped = 2;
    end else if (cfg_even > r2y420_pkg::MAX_HEIGHT) begin
      height_clamped = r2y420_pkg::MAX_HEIGHT;
    end
  end

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_lim  <= r2y420_pkg::WIDTH_RESET;
      height_lim <= r2y420_pkg::HEIGHT_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        r2y420_pkg::REG_FRAME_WIDTH: begin
          width_lim <= r2y420_pkg::WLIM_W'(width_clamped);
        end
        r2y420_pkg::REG_FRAME_HEIGHT: begin
          height_lim <= r2y420_pkg::HLIM_W'(height_clamped);
        end
        default: begin
        end
      endcase
    end
  end

  // handshake
  logic   s1_valid;
  stage_t s1;
  logic   out_valid;
  logic   s2_ready;
  logic   s1_move;
  logic   in_ready;
  logic   accept;

  assign s2_ready       = !out_valid || results.ready;
  assign s1_move        = s1_valid && s2_ready;
  assign in_ready       = !s1_valid || s2_ready;
  assign accept         = pixels.valid && in_ready;
  assign pixels.ready   = in_ready;

  // position tracking
  logic [r2y420_pkg::COL_W-1:0]  column_count;
  logic [r2y420_pkg::ROW_W-1:0]  row_count;
  logic [r2y420_pkg::COL_W-1:0]  column_count_next;
  logic [r2y420_pkg::ROW_W-1:0]  row_count_next;
  logic                          col_last;
  logic                          row_last;
  logic [3*PW-1:0]               left_pixel;

  assign col_last = ({1'b0, column_count} + r2y420_pkg::WLIM_W'(1)) >= width_lim;
  assign row_last = ({1'b0, row_count} + r2y420_pkg::HLIM_W'(1)) >= height_lim;

  always_comb begin
    column_count_next = column_count + r2y420_pkg::COL_W'(1);
    row_count_next    = row_count;
    if (col_last) begin
      column_count_next = '0;
      row_count_next    = row_last ? '0 : row_count + r2y420_pkg::ROW_W'(1);
    end
  end

  // line store of pair sums from the even row
  logic                                ram_wen;
  logic                                ram_ren;
  logic [r2y420_pkg::LINE_ADDR_W-1:0]  line_addr;
  logic [r2y420_pkg::ENTRY_W-1:0]      ram_wdata;
  logic [r2y420_pkg::ENTRY_W-1:0]      ram_rdata;
  logic [SW-1:0]                       sum_red;
  logic [SW-1:0]                       sum_green;
  logic [SW-1:0]                       sum_blue;
  logic [SW:0]                         quad_red;
  logic [SW:0]                         quad_green;
  logic [SW:0]                         quad_blue;

  assign line_addr = r2y420_pkg::LINE_ADDR_W'(column_count >> 1);
  assign ram_wen   = accept && column_count[0] && !row_count[0];
  assign ram_ren   = accept && !column_count[0];

  assign sum_red   = {1'b0, pixels.red}   + {1'b0, left_pixel[3*PW-1:2*PW]};
  assign sum_green = {1'b0, pixels.green} + {1'b0, left_pixel[2*PW-1:PW]};
  assign sum_blue  = {1'b0, pixels.blue}  + {1'b0, left_pixel[PW-1:0]};
  assign ram_wdata = {sum_red, sum_green, sum_blue};

  assign quad_red   = {1'b0, sum_red}   + {1'b0, ram_rdata[3*SW-1:2*SW]};
  assign quad_green = {1'b0, sum_green} + {1'b0, ram_rdata[2*SW-1:SW]};
  assign quad_blue  = {1'b0, sum_blue}  + {1'b0, ram_rdata[SW-1:0]};

  r2y420_ram #(
    .WIDTH (r2y420_pkg::ENTRY_W),
    .DEPTH (r2y420_pkg::LINE_DEPTH)
  ) u_line_store (
    .clk   (clk),
    .wen   (ram_wen),
    .waddr (line_addr),
    .wdata (ram_wdata),
    .ren   (ram_ren),
    .raddr (line_addr),
    .rdata (ram_rdata)
  );

  // stage 1: counters, pair sums, 2x2 averages
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      left_pixel   <= '0;
      s1_valid     <= 1'b0;
    end else begin
      if (accept) begin
        column_count <= column_count_next;
        row_count    <= row_count_next;
        if (!column_count[0]) begin
          left_pixel <= {pixels.red, pixels.green, pixels.blue};
        end
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1.red          <= pixels.red;
      s1.green        <= pixels.green;
      s1.blue         <= pixels.blue;
      s1.avg_red      <= quad_red[SW:2];
      s1.avg_green    <= quad_green[SW:2];
      s1.avg_blue     <= quad_blue[SW:2];
      s1.chroma_valid <= column_count[0] && row_count[0];
      s1.frame_last   <= col_last && row_last;
    end
  end

  // stage 2: constant multiplies into the result register
  logic [AW-1:0] y_acc;
  logic [AW-1:0] u_acc;
  logic [AW-1:0] v_acc;

  assign y_acc = AW'(r2y420_pkg::COEF_YR * s1.red)
               + AW'(r2y420_pkg::COEF_YG * s1.green)
               + AW'(r2y420_pkg::COEF_YB * s1.blue);
  // numerators stay positive, so modular arithmetic at AW bits is exact
  assign u_acc = r2y420_pkg::CHROMA_OFFSET
               + AW'(r2y420_pkg::COEF_UV * s1.avg_blue)
               - AW'(r2y420_pkg::COEF_UR * s1.avg_red)
               - AW'(r2y420_pkg::COEF_UG * s1.avg_green);
  assign v_acc = r2y420_pkg::CHROMA_OFFSET
               + AW'(r2y420_pkg::COEF_UV * s1.avg_red)
               - AW'(r2y420_pkg::COEF_VG * s1.avg_green)
               - AW'(r2y420_pkg::COEF_VB * s1.avg_blue);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      results.luma         <= y_acc[F+PW-1:F] + r2y420_pkg::LUMA_OFFSET;
      results.chroma_valid <= s1.chroma_valid;
      results.chroma_blue  <= s1.chroma_valid ? u_acc[F+PW-1:F] : '0;
      results.chroma_red   <= s1.chroma_valid ? v_acc[F+PW-1:F] : '0;
      results.frame_last   <= s1.frame_last;
    end
  end

  assign results.valid = out_valid;

  // checks
  a_line_port_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(ram_wen && ram_ren))
    else $error("line store written and read in the same cycle");

  a_stage1_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s2_ready |=> s1_valid && $stable(s1))
    else $error("stage 1 lost or changed a stalled pixel");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> pixels.ready)
    else $error("input stalled with empty pipeline");

  a_chroma_zero: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.chroma_valid |->
      results.chroma_blue == '0 && results.chroma_red == '0)
    else $error("chroma fields not zero outside block corner");

  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    accept && col_last && row_last |=> column_count == '0 && row_count == '0)
    else $error("counters did not wrap at frame end");

endmodule

@@ tb/sv/rgb_to_yuv420_converter_checker.sv @@
// Stream checker for the RGB to YUV 4:2:0 converter: predicts each pixel's result and compares.
`timescale 1ns / 1ps

module rgb_to_yuv420_checker
  import r2y420_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  r2y420_pix_if pix,
  r2y420_res_if res,
  r2y420_cfg_if cfg,
  output int    mismatches,
  output int    pending,
  output logic  odd_row,
  output int    chroma_blocks,
  output int    frame_ends
);

  localparam int WIDTH_CAP  = 4096;
  localparam int HEIGHT_CAP = 4096;
  localparam int LINE_SLOTS = WIDTH_CAP / 2;

  // Q0.16 coefficients, truncated
  localparam longint K_Y_R       = (longint'(257) << 16) / 1000;
  localparam longint K_Y_G       = (longint'(504) << 16) / 1000;
  localparam longint K_Y_B       = (longint'(98) << 16) / 1000;
  localparam longint K_U_R       = (longint'(148) << 16) / 1000;
  localparam longint K_U_G       = (longint'(291) << 16) / 1000;
  localparam longint K_UV_MAIN   = (longint'(439) << 16) / 1000;
  localparam longint K_V_G       = (longint'(368) << 16) / 1000;
  localparam longint K_V_B       = (longint'(71) << 16) / 1000;
  localparam longint CHROMA_BASE = longint'(128) << 16;

  typedef struct packed {
    logic [7:0] luma;
    logic       chroma_valid;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;
    logic       frame_last;
  } yuv_t;

  logic [12:0] width_raw;
  logic [12:0] height_raw;
  int          col_pos;
  int          row_pos;
  logic [23:0] left_rgb;
  logic [26:0] pair_sums [LINE_SLOTS];
  yuv_t        expected_yuv [$];

  function automatic int frame_dim(input logic [12:0] raw, input int cap);
    int v;
    v = int'(raw) & ~1;
    if (v < 2) return 2;
    if (v > cap) return cap;
    return v;
  endfunction

  function automatic yuv_t convert_pixel(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b);
    yuv_t        yuv;
    int          w, h, slot;
    bit          col_end, row_end;
    logic [8:0]  sr, sg, sb;
    logic [26:0] above;
    longint      y, ar, ag, ab, un, vn;
    w = frame_dim(width_raw, WIDTH_CAP);
    h = frame_dim(height_raw, HEIGHT_CAP);
    col_end = (col_pos + 1 >= w);
    row_end = (row_pos + 1 >= h);
    yuv = '0;
    y = K_Y_R * r + K_Y_G * g + K_Y_B * b;
    yuv.luma = 8'((y >> 16) + 16);
    if (!col_pos[0]) begin
      left_rgb = {r, g, b};
    end else begin
      slot = (col_pos >> 1) % LINE_SLOTS;
      sr = r + left_rgb[23:16];
      sg = g + left_rgb[15:8];
      sb = b + left_rgb[7:0];
      if (!row_pos[0]) begin
        pair_sums[slot] = {sr, sg, sb};
      end else begin
        above = pair_sums[slot];
        ar = (longint'(sr) + above[26:18]) >> 2;
        ag = (longint'(sg) + above[17:9]) >> 2;
        ab = (longint'(sb) + above[8:0]) >> 2;
        un = CHROMA_BASE + K_UV_MAIN * ab - K_U_R * ar - K_U_G * ag;
        vn = CHROMA_BASE + K_UV_MAIN * ar - K_V_G * ag - K_V_B * ab;
        yuv.chroma_valid = 1'b1;
        yuv.chroma_blue  = un[23:16];
        yuv.chroma_red   = vn[23:16];
      end
    end
    yuv.frame_last = col_end && row_end;
    if (col_end) begin
      col_pos = 0;
      row_pos = row_end ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
    return yuv;
  endfunction

  always @(posedge clk) begin
    yuv_t seen, want;
    if (rst) begin
      width_raw     = 13'(640);
      height_raw    = 13'(480);
      col_pos       = 0;
      row_pos       = 0;
      left_rgb      = '0;
      expected_yuv.delete();
      mismatches    = 0;
      chroma_blocks = 0;
      frame_ends    = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_FRAME_WIDTH) width_raw = cfg.data;
        else if (cfg.index == REG_FRAME_HEIGHT) height_raw = cfg.data;
      end
      // retire before predicting: a result never belongs to a pixel taken at the same edge
      if (res.valid && res.ready) begin
        seen = '{res.luma, res.chroma_valid, res.chroma_blue, res.chroma_red, res.frame_last};
        if (seen.chroma_valid === 1'b1) chroma_blocks++;
        if (seen.frame_last === 1'b1) frame_ends++;
        if (expected_yuv.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result request with none expected: luma %0d", $realtime, seen.luma);
          mismatches++;
        end else begin
          want = expected_yuv.pop_front();
          if (seen !== want) begin
            if (mismatches < 10)
              $display("%0t: exp/got Y %0d/%0d cv %0d/%0d U %0d/%0d V %0d/%0d last %0d/%0d",
                       $realtime,
                       want.luma, seen.luma, want.chroma_valid, seen.chroma_valid,
                       want.chroma_blue, seen.chroma_blue, want.chroma_red, seen.chroma_red,
                       want.frame_last, seen.frame_last);
            mismatches++;
          end
        end
      end
      if (pix.valid && pix.ready)
        expected_yuv.push_back(convert_pixel(pix.red, pix.green, pix.blue));
    end
    pending = expected_yuv.size();
    odd_row = row_pos[0];
  end

endmodule

@@ tb/sv/rgb_to_yuv420_converter_tb.sv @@
// Top-level testbench for the RGB to YUV 4:2:0 converter: stimulus, idling and verdict.
`timescale 1ns / 1ps

module rgb_to_yuv420_converter_tb;
  import r2y420_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 10 * HOLD_CYCLES;
  localparam int PHASES       = 8;
  localparam int PHASE_PIXELS = 112;

  // indexes past the register map; writes to them must change nothing
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = CFG_INDEX_W'(3);

  logic clk = 1'b0;
  logic rst;

  r2y420_pix_if pix_bus ();
  r2y420_res_if res_bus ();
  r2y420_cfg_if cfg_bus ();

  int   mismatches, pending, chroma_blocks, frame_ends;
  logic odd_row;

  int sender_idle_pct;
  int result_stall_pct;
  int holds_asked;
  int holds_served = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int pixels_sent;
  int reg_writes;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  rgb_to_yuv420_converter uut (
    .clk     (clk),
    .rst     (rst),
    .pixels  (pix_bus),
    .results (res_bus),
    .cfg     (cfg_bus)
  );

  rgb_to_yuv420_checker yuv_check (
    .clk           (clk),
    .rst           (rst),
    .pix           (pix_bus),
    .res           (res_bus),
    .cfg           (cfg_bus),
    .mismatches    (mismatches),
    .pending       (pending),
    .odd_row       (odd_row),
    .chroma_blocks (chroma_blocks),
    .frame_ends    (frame_ends)
  );

  // result side: random stalls, plus a long hold-off when asked
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      res_bus.ready <= 1'b0;
    end else if (holds_served != holds_asked) begin
      holds_served = holds_served + 1;
      hold_left = HOLD_CYCLES - 1;
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= ($urandom_range(99) >= result_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (pix_bus.valid && pix_bus.ready) || (res_bus.valid && res_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no request moved for %0d cycles", $realtime, quiet_cycles);
      $display("rgb_to_yuv420_converter_tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [7:0] pick_byte();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return 8'd0;
    if (sel == 1) return 8'd255;
    return 8'($urandom_range(255));
  endfunction

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      pix_bus.valid <= 1'b0;
      @(negedge clk);
    end
    pix_bus.valid <= 1'b1;
    pix_bus.red   <= r;
    pix_bus.green <= g;
    pix_bus.blue  <= b;
    do @(posedge clk); while (!pix_bus.ready);
    pixels_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    pix_bus.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
    reg_writes++;
  endtask

  initial begin
    int phase, n;
    logic [CFG_DATA_W-1:0] size_raw;
    rst              = 1'b1;
    pix_bus.valid    = 1'b0;
    pix_bus.red      = '0;
    pix_bus.green    = '0;
    pix_bus.blue     = '0;
    cfg_bus.valid    = 1'b0;
    cfg_bus.index    = REG_FRAME_WIDTH;
    cfg_bus.data     = '0;
    sender_idle_pct  = 0;
    result_stall_pct = 0;
    holds_asked      = 0;
    pixels_sent      = 0;
    reg_writes       = 0;
    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // 4x2 frame (odd values, low bit dropped): an all-blue and an all-red block
    write_reg(REG_FRAME_WIDTH, 5);
    write_reg(REG_FRAME_HEIGHT, 3);
    repeat (2) begin
      send_pixel(8'd0, 8'd0, 8'd255);
      send_pixel(8'd0, 8'd0, 8'd255);
      send_pixel(8'd255, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd0, 8'd0);
    end
    wait_drained();

    // sizes below range clamp to 2x2
    write_reg(REG_FRAME_WIDTH, 0);
    write_reg(REG_FRAME_HEIGHT, 1);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd1, 8'd128, 8'd254);
    send_pixel(8'd255, 8'd255, 8'd255);
    wait_drained();

    write_reg(REG_SPARE_A, '1);
    write_reg(REG_SPARE_B, '1);
    // saturates to the widest line
    write_reg(REG_FRAME_WIDTH, '1);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd128, 8'd127, 8'd1);
    send_pixel(8'd254, 8'd2, 8'd129);
    wait_drained();
    // narrowing mid-row: column is already past the new end and wraps
    write_reg(REG_FRAME_WIDTH, 2);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    wait_drained();

    write_reg(REG_FRAME_HEIGHT, '1);
    send_pixel(8'd85, 8'd170, 8'd85);
    send_pixel(8'd170, 8'd85, 8'd170);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    wait_drained();
    // row counter past the new last row wraps after this row
    write_reg(REG_FRAME_HEIGHT, 2);
    send_pixel(8'd16, 8'd32, 8'd64);
    send_pixel(8'd240, 8'd224, 8'd192);

    for (phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      // width only moves on an even row, so odd rows read only stored pair sums
      if (!odd_row && $urandom_range(9) < 7) begin
        size_raw = ($urandom_range(99) < 8) ? CFG_DATA_W'($urandom_range(8191))
                                            : CFG_DATA_W'($urandom_range(24));
        write_reg(REG_FRAME_WIDTH, size_raw);
      end
      if ($urandom_range(9) < 7) begin
        size_raw = ($urandom_range(99) < 8) ? CFG_DATA_W'($urandom_range(8191))
                                            : CFG_DATA_W'($urandom_range(12));
        write_reg(REG_FRAME_HEIGHT, size_raw);
      end
      if ($urandom_range(9) == 0)
        write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B,
                  CFG_DATA_W'($urandom_range(8191)));
      case (phase % 4)
        0: begin sender_idle_pct = 0;  result_stall_pct = 0;  end
        1: begin sender_idle_pct = 58; result_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  result_stall_pct = 58; end
        default: begin sender_idle_pct = 6; result_stall_pct = 6; end
      endcase
      for (n = 0; n < PHASE_PIXELS; n++) begin
        if (n == PHASE_PIXELS / 2) begin
          if (phase % 4 == 0) holds_asked++;  // sender keeps pushing into a full pipe
          else wait_drained();
        end
        send_pixel(pick_byte(), pick_byte(), pick_byte());
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    $display("covered %0d pixels, %0d register writes, %0d chroma blocks, %0d frame ends",
             pixels_sent, reg_writes, chroma_blocks, frame_ends);
    $display("idle mixes: none, sender, result side, both; %0d long result hold-offs",
             holds_served);
    if (mismatches == 0 && pending == 0) begin
      $display("rgb_to_yuv420_converter_tb: done, clean");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending);
      $display("rgb_to_yuv420_converter_tb: done, errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/r2y420_pkg.sv
hw/rtl/r2y420_if.sv
hw/rtl/r2y420_ram.sv
hw/rtl/rgb_to_yuv420_converter.sv
tb/sv/rgb_to_yuv420_converter_checker.sv
tb/sv/rgb_to_yuv420_converter_tb.sv
